>>> rtl/radio_airtime_tx_timer_macros.svh
`ifndef RADIO_AIRTIME_TX_TIMER_MACROS_SVH
`define RADIO_AIRTIME_TX_TIMER_MACROS_SVH

// check a condition at every edge outside reset
`define RAT_ASSERT_HOLD(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// check a consequence in the cycle after an antecedent
`define RAT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rat_pkg.sv
package rat_pkg;

   localparam int SF_W        = 4;
   localparam int BW_W        = 19;
   localparam int CR_W        = 3;
   localparam int ACT_W       = 2;
   localparam int LEN_W       = 8;
   localparam int TIME_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 19;
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 72;

   localparam int FRAC_BITS_DEF = 16;
   localparam int PREAMBLE_DEF  = 8;

   localparam int SYM_BASE      = 1000;
   localparam int BASE_W        = 10;
   localparam int SF_MAX        = (1 << SF_W) - 1;
   localparam int PAY_W         = 10;
   localparam int CODED_W       = 13;
   localparam int CODED_MAX     = (1 << CODED_W) - 1;
   localparam int LDRO_MS       = 16;
   localparam int SYNC_QUARTERS = 17;
   localparam int HDR_SYMS      = 8;
   localparam int HDR_OFFSET    = 11;

   localparam logic [SF_W-1:0] SF_RESET = SF_W'(7);
   localparam logic [BW_W-1:0] BW_RESET = BW_W'(125000);
   localparam logic [CR_W-1:0] CR_RESET = CR_W'(1);

   localparam logic [ACT_W-1:0] ACT_START    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_POLL     = 2'd1;
   localparam logic [ACT_W-1:0] ACT_ESTIMATE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CR = 2'd2;

   typedef struct packed {
      logic load;
      logic sym_start;
      logic div_step;
      logic pay_start;
      logic mul_start;
      logic mul_step;
      logic commit;
   } rat_cmd_type;

   typedef struct packed {
      logic poll;
      logic bw_zero;
      logic pay_skip;
   } rat_sts_type;

   function automatic int num_width(input int frac);
      return BASE_W + SF_MAX + frac;
   endfunction

   function automatic int quart_width(input int pre);
      return $clog2(4 * pre + SYNC_QUARTERS + 4 * HDR_SYMS + 4 * CODED_MAX + 1);
   endfunction

endpackage

>>> rtl/rat_ctrl.sv
module rat_ctrl #(
   parameter int FRAC_BITS        = rat_pkg::FRAC_BITS_DEF,
   parameter int PREAMBLE_SYMBOLS = rat_pkg::PREAMBLE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  rat_pkg::rat_sts_type sts,
   output rat_pkg::rat_cmd_type cmd
);
   import rat_pkg::*;

   localparam int NUM_W    = num_width(FRAC_BITS);
   localparam int QW       = quart_width(PREAMBLE_SYMBOLS);
   localparam int STEP_MAX = (NUM_W > QW) ? NUM_W : QW;
   localparam int CNT_W    = $clog2(STEP_MAX + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SYM_DIV,
      S_PAY_SET,
      S_PAY_DIV,
      S_MUL_SET,
      S_MUL,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.load     = req_tvalid && (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.poll || sts.bw_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.sym_start = 1'b1;
               cnt_in        = CNT_W'(NUM_W);
               state_in      = S_SYM_DIV;
            end
         end
         S_SYM_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_PAY_SET;
            end
         end
         S_PAY_SET: begin
            cmd.pay_start = 1'b1;
            if (sts.pay_skip) begin
               state_in = S_MUL_SET;
            end else begin
               cnt_in   = CNT_W'(PAY_W);
               state_in = S_PAY_DIV;
            end
         end
         S_PAY_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_MUL_SET;
            end
         end
         S_MUL_SET: begin
            cmd.mul_start = 1'b1;
            cnt_in        = CNT_W'(QW);
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/rat_dp.sv
module rat_dp #(
   parameter int FRAC_BITS        = rat_pkg::FRAC_BITS_DEF,
   parameter int PREAMBLE_SYMBOLS = rat_pkg::PREAMBLE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rat_pkg::rat_cmd_type               cmd,
   output rat_pkg::rat_sts_type               sts,
   input  logic [rat_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  logic [rat_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic [rat_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   input  logic [rat_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rat_pkg::CSR_DATA_W-1:0]     csr_data
);
   import rat_pkg::*;

   localparam int NUM_W  = num_width(FRAC_BITS);
   localparam int QW     = quart_width(PREAMBLE_SYMBOLS);
   localparam int PW     = QW + NUM_W;
   localparam int QBASE  = 4 * PREAMBLE_SYMBOLS + SYNC_QUARTERS + 4 * HDR_SYMS;
   localparam int NP_W   = LEN_W + 3;
   localparam int AIR_LO = FRAC_BITS + 2;
   localparam int AIR_HI = FRAC_BITS + 1 + TIME_W;

   logic [SF_W-1:0]   sf_ff;
   logic [BW_W-1:0]   bw_ff;
   logic [CR_W-1:0]   cr_ff;

   logic [ACT_W-1:0]  act_ff;
   logic [TIME_W-1:0] now_ff;
   logic [LEN_W-1:0]  len_ff;

   logic [BW_W-1:0]   div_rem_ff, div_rem_in;
   logic [NUM_W-1:0]  div_quo_ff, div_quo_in;
   logic [BW_W-1:0]   div_dvs_ff, div_dvs_in;
   logic [NUM_W-1:0]  tsym_ff;
   logic              pay_skip_ff;
   logic [QW-1:0]     mul_q_ff, mul_q_in;
   logic [PW-1:0]     mul_acc_ff, mul_acc_in;

   logic              pending_ff, pending_in;
   logic [TIME_W-1:0] done_ff, done_in;
   logic [TIME_W-1:0] out_air_ff, out_air_in;
   logic [TIME_W-1:0] out_done_ff;
   logic              out_complete_ff, out_complete_in;
   logic              out_pending_ff;

   logic [BW_W:0]         trial, diff;
   logic                  ge;
   logic                  ldro;
   logic [NP_W-1:0]       np_sum, np_diff;
   logic                  num_pos, den_pos, pay_skip;
   logic [SF_W-1:0]       den_val;
   logic [PAY_W-1:0]      q_ceil;
   logic [CR_W:0]         cr4;
   logic [PAY_W+CR_W:0]   coded_full;
   logic [CODED_W-1:0]    coded;
   logic [QW-1:0]         quarters;
   logic                  over;
   logic [TIME_W-1:0]     air;

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff <= SF_RESET;
         bw_ff <= BW_RESET;
         cr_ff <= CR_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SF:  sf_ff <= csr_data[SF_W-1:0];
            CSR_BW:  bw_ff <= csr_data[BW_W-1:0];
            CSR_CR:  cr_ff <= csr_data[CR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_tuser;
         now_ff <= req_tdata[TIME_W-1:0];
         len_ff <= req_tdata[TIME_W+LEN_W-1:TIME_W];
      end
   end

   // shared restoring divider, one quotient bit a beat of the counter
   assign trial = {div_rem_ff, div_quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, div_dvs_ff};
   assign ge    = (trial >= {1'b0, div_dvs_ff});

   assign ldro    = (div_quo_ff >= (NUM_W'(LDRO_MS) << FRAC_BITS));
   assign np_sum  = {2'b00, len_ff, 1'b0} + NP_W'(HDR_OFFSET);
   assign np_diff = np_sum - NP_W'(sf_ff);
   assign num_pos = (np_sum > NP_W'(sf_ff));
   assign den_pos = ldro ? (sf_ff > SF_W'(2)) : (sf_ff != '0);
   assign den_val = sf_ff - SF_W'({ldro, 1'b0});
   assign pay_skip = !(num_pos && den_pos);

   always_comb begin
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_dvs_in = div_dvs_ff;
      if (cmd.sym_start) begin
         div_rem_in = '0;
         div_quo_in = (NUM_W'(SYM_BASE) << FRAC_BITS) << sf_ff;
         div_dvs_in = bw_ff;
      end else if (cmd.pay_start) begin
         div_rem_in = '0;
         div_quo_in = NUM_W'(np_diff[PAY_W-1:0]) << (NUM_W - PAY_W);
         div_dvs_in = BW_W'(den_val);
      end else if (cmd.div_step) begin
         div_rem_in = ge ? diff[BW_W-1:0] : trial[BW_W-1:0];
         div_quo_in = {div_quo_ff[NUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_dvs_ff <= div_dvs_in;
      if (cmd.pay_start) begin
         tsym_ff     <= div_quo_ff;
         pay_skip_ff <= pay_skip;
      end
   end

   // payload symbols, then shift-add product of quarter symbols and symbol time
   assign q_ceil     = div_quo_ff[PAY_W-1:0] + PAY_W'(div_rem_ff != '0);
   assign cr4        = {1'b0, cr_ff} + (CR_W+1)'(4);
   assign coded_full = q_ceil * cr4;
   assign coded      = pay_skip_ff ? '0 : coded_full[CODED_W-1:0];
   assign quarters   = QW'(QBASE) + QW'({coded, 2'b00});

   always_comb begin
      mul_q_in   = mul_q_ff;
      mul_acc_in = mul_acc_ff;
      if (cmd.mul_start) begin
         mul_q_in   = quarters;
         mul_acc_in = '0;
      end else if (cmd.mul_step) begin
         mul_q_in   = mul_q_ff << 1;
         mul_acc_in = {mul_acc_ff[PW-2:0], 1'b0} + (mul_q_ff[QW-1] ? PW'(tsym_ff) : '0);
      end
   end

   always_ff @(posedge clock) begin
      mul_q_ff   <= mul_q_in;
      mul_acc_ff <= mul_acc_in;
   end

   assign over = |mul_acc_ff[PW-1:AIR_HI+1];
   assign air  = (sts.bw_zero || over) ? '1 : mul_acc_ff[AIR_HI:AIR_LO];

   always_comb begin
      pending_in      = pending_ff;
      done_in         = done_ff;
      out_air_in      = air;
      out_complete_in = 1'b0;
      case (act_ff)
         ACT_START: begin
            pending_in = 1'b1;
            done_in    = now_ff + air;
         end
         ACT_POLL: begin
            out_air_in = '0;
            if (pending_ff && (now_ff >= done_ff)) begin
               out_complete_in = 1'b1;
               pending_in      = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         done_ff    <= '0;
      end else if (cmd.commit) begin
         pending_ff <= pending_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_air_ff      <= out_air_in;
         out_done_ff     <= done_in;
         out_complete_ff <= out_complete_in;
         out_pending_ff  <= pending_in;
      end
   end

   assign sts.poll     = (act_ff == ACT_POLL);
   assign sts.bw_zero  = (bw_ff == '0);
   assign sts.pay_skip = pay_skip;

   assign rsp_tdata = {(RSP_TDATA_W-2*TIME_W-2)'(0), out_pending_ff, out_complete_ff,
                       out_done_ff, out_air_ff};

endmodule

>>> rtl/radio_airtime_tx_timer.sv
// Packet airtime calculator with one pending transmit. A start or estimate item runs
// through the check state; then the bit-serial divider yields one quotient bit a cycle
// for the symbol time and again for the payload symbol count (unless the payload is
// skipped), the shift-add multiplier takes one bit of the quarter-symbol count (QW bits,
// 16 at the default preamble) a cycle, and the result is committed in the done state.
// A poll item, or any item while the bandwidth is zero, goes from the check state
// straight to the done state. One item is in flight at a time; the next is taken while
// the previous result still waits on the output register. Configuration writes are
// always ready and update the settings at once, so a write during an item can alter it.
module radio_airtime_tx_timer #(
   parameter int FRAC_BITS        = rat_pkg::FRAC_BITS_DEF,
   parameter int PREAMBLE_SYMBOLS = rat_pkg::PREAMBLE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rat_pkg::REQ_TUSER_W-1:0] req_tuser,  // action
   input  logic [rat_pkg::REQ_TDATA_W-1:0] req_tdata,  // now_ms, length
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rat_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // airtime_ms, done_at_ms, complete, pending
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rat_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rat_pkg::*;

   rat_cmd_type cmd;
   rat_sts_type sts;

   assign csr_ready = 1'b1;

   rat_ctrl #(
      .FRAC_BITS        (FRAC_BITS),
      .PREAMBLE_SYMBOLS (PREAMBLE_SYMBOLS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rat_dp #(
      .FRAC_BITS        (FRAC_BITS),
      .PREAMBLE_SYMBOLS (PREAMBLE_SYMBOLS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

>>> rtl/rat_checker.sv
`include "radio_airtime_tx_timer_macros.svh"

module rat_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rat_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import rat_pkg::*;

   localparam int COMPLETE_BIT = 2 * TIME_W;
   localparam int PENDING_BIT  = 2 * TIME_W + 1;

   `RAT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result beat dropped while stalled")
   `RAT_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "result beat changed while stalled")
   `RAT_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "second beat taken while busy")
   `RAT_ASSERT_HOLD(a_poll_done, !(rsp_tvalid && rsp_tdata[COMPLETE_BIT]) || (rsp_tdata[TIME_W-1:0] == '0 && !rsp_tdata[PENDING_BIT]), "completion with airtime or still pending")

endmodule

bind radio_airtime_tx_timer rat_checker u_checker (.*);
